### rtl/gvm_pkg.sv
// Shared types, constants and codes for the gaze voltage mapper and spike filter.
package gvm_pkg;

  // Image geometry in whole pixels.
  localparam int unsigned IMG_WIDTH  = 640;
  localparam int unsigned IMG_HEIGHT = 480;

  // Field widths.
  localparam int unsigned PIX_W    = 16;
  localparam int unsigned GAIN_W   = 9;
  localparam int unsigned GAIN_Y_W = 8;
  localparam int unsigned RANGE_W  = 16;
  localparam int unsigned VOLT_W   = 16;
  localparam int unsigned MODE_W   = 3;

  // Arithmetic widths: signed pixel difference, product, divisor, accumulator.
  localparam int unsigned DIFF_W   = PIX_W + 2;
  localparam int unsigned NUM_W    = DIFF_W + RANGE_W + 1;
  localparam int unsigned NMAG_W   = 32;
  localparam int unsigned DBASE_W  = 14;
  localparam int unsigned DEN_W    = DBASE_W + 4;
  localparam int unsigned DMAG_W   = DEN_W - 1;
  localparam int unsigned ACC_W    = NMAG_W + 4;
  localparam int unsigned DIST_W   = VOLT_W + 1;

  // One divide step per quotient bit.
  localparam int unsigned DIV_CNT_W = $clog2(NMAG_W);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Lane numbering.
  localparam int unsigned LANE_X = 0;
  localparam int unsigned LANE_Y = 1;
  localparam int unsigned LANES  = 2;

  // Mode bit positions.
  localparam int unsigned MODE_FILT  = 0;
  localparam int unsigned MODE_INV_X = 1;
  localparam int unsigned MODE_INV_Y = 2;

  // Number of samples taken in before the filter runs.
  localparam logic [1:0] FILL_FULL = 2'd3;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_X   = 3'd0,
    REG_GAIN_Y   = 3'd1,
    REG_RANGE    = 3'd2,
    REG_OUT_MIN  = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5,
    REG_MODE     = 3'd6
  } cfg_reg_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_e;

  // Input and output words.
  typedef struct packed {
    logic [PIX_W-1:0] pupil_x;
    logic [PIX_W-1:0] pupil_y;
  } in_word_t;

  typedef struct packed {
    logic signed [VOLT_W-1:0] volt_x_mv;
    logic signed [VOLT_W-1:0] volt_y_mv;
    logic                     clipped;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mul;
    logic load;
    logic step;
    logic fin;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

### rtl/gvm_div.sv
// Restoring unsigned divider, one quotient bit per step.
module gvm_div (
  input  logic                           clk_i,
  input  logic                           load_i,
  input  logic                           step_i,
  input  logic [gvm_pkg::NMAG_W-1:0]     dividend_i,
  input  logic [gvm_pkg::DMAG_W-1:0]     divisor_i,
  output logic [gvm_pkg::NMAG_W-1:0]     quotient_o
);

  logic [gvm_pkg::DMAG_W-1:0] dvs_q;
  logic [gvm_pkg::DMAG_W-1:0] rem_q, rem_d;
  logic [gvm_pkg::NMAG_W-1:0] quo_q, quo_d;
  logic [gvm_pkg::DMAG_W:0]   shifted;
  logic [gvm_pkg::DMAG_W:0]   trial;
  logic                       ge;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    shifted = {rem_q, quo_q[gvm_pkg::NMAG_W-1]};
    ge      = shifted >= {1'b0, dvs_q};
    trial   = shifted - {1'b0, dvs_q};
    rem_d   = ge ? trial[gvm_pkg::DMAG_W-1:0] : shifted[gvm_pkg::DMAG_W-1:0];
    quo_d   = {quo_q[gvm_pkg::NMAG_W-2:0], ge};
  end

  // The dividend register fills with quotient bits from the bottom.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (step_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;

endmodule

### rtl/gvm_datapath.sv
// Datapath: configuration registers, mapping, dividers, spike filter and output register.
module gvm_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gvm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gvm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  gvm_pkg::in_word_t                  in_word_i,
  input  gvm_pkg::cmd_t                      cmd_i,
  output gvm_pkg::sts_t                      sts_o,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output gvm_pkg::out_word_t                 out_word_o
);

  localparam logic signed [gvm_pkg::DBASE_W-1:0] SIZE_X =
    gvm_pkg::DBASE_W'(gvm_pkg::IMG_WIDTH);
  localparam logic signed [gvm_pkg::DBASE_W-1:0] SIZE_Y =
    gvm_pkg::DBASE_W'(gvm_pkg::IMG_HEIGHT);

  // Configuration registers.
  logic [gvm_pkg::GAIN_W-1:0]          gain_x_q;
  logic [gvm_pkg::GAIN_Y_W-1:0]        gain_y_q;
  logic [gvm_pkg::RANGE_W-1:0]         range_q;
  logic signed [gvm_pkg::VOLT_W-1:0]   out_min_q;
  logic signed [gvm_pkg::VOLT_W-1:0]   offset_x_q;
  logic signed [gvm_pkg::VOLT_W-1:0]   offset_y_q;
  logic [gvm_pkg::MODE_W-1:0]          mode_q;

  // Per-lane working registers.
  logic [gvm_pkg::LANES-1:0][gvm_pkg::PIX_W-1:0]          pix_q;
  logic signed [gvm_pkg::NUM_W-1:0]                       num_q  [gvm_pkg::LANES];
  logic signed [gvm_pkg::DEN_W-1:0]                       den_q  [gvm_pkg::LANES];
  logic [gvm_pkg::LANES-1:0]                              neg_q;
  logic [gvm_pkg::LANES-1:0]                              dzero_q;
  logic signed [gvm_pkg::VOLT_W-1:0]                      map_q  [gvm_pkg::LANES];
  logic                                                   clip_q;

  // History: newest and previous sample per lane, and the fill count.
  logic signed [gvm_pkg::VOLT_W-1:0] h0_q [gvm_pkg::LANES];
  logic signed [gvm_pkg::VOLT_W-1:0] h1_q [gvm_pkg::LANES];
  logic signed [gvm_pkg::VOLT_W-1:0] h0_d [gvm_pkg::LANES];
  logic signed [gvm_pkg::VOLT_W-1:0] h1_d [gvm_pkg::LANES];
  logic [1:0]                        fill_q, fill_d;

  // Output register.
  logic                 out_valid_q;
  gvm_pkg::out_word_t   out_q;

  // Combinational per-lane signals.
  logic [gvm_pkg::LANES-1:0][gvm_pkg::GAIN_W-1:0]  gain;
  logic signed [gvm_pkg::DBASE_W-1:0]              size   [gvm_pkg::LANES];
  logic signed [gvm_pkg::VOLT_W-1:0]               offset [gvm_pkg::LANES];
  logic [gvm_pkg::LANES-1:0]                       invert;
  logic signed [gvm_pkg::DIFF_W-1:0]               diff   [gvm_pkg::LANES];
  logic signed [gvm_pkg::NUM_W-1:0]                num_d  [gvm_pkg::LANES];
  logic signed [gvm_pkg::DBASE_W-1:0]              dbase  [gvm_pkg::LANES];
  logic signed [gvm_pkg::NUM_W-1:0]                num_abs [gvm_pkg::LANES];
  logic signed [gvm_pkg::DEN_W-1:0]                den_abs [gvm_pkg::LANES];
  logic [gvm_pkg::NMAG_W-1:0]                      quo    [gvm_pkg::LANES];
  logic signed [gvm_pkg::ACC_W-1:0]                qs     [gvm_pkg::LANES];
  logic signed [gvm_pkg::ACC_W-1:0]                v      [gvm_pkg::LANES];
  logic signed [gvm_pkg::ACC_W-1:0]                r      [gvm_pkg::LANES];
  logic signed [gvm_pkg::VOLT_W-1:0]               sat    [gvm_pkg::LANES];
  logic [gvm_pkg::LANES-1:0]                       clip_l;
  logic signed [gvm_pkg::DIST_W-1:0]               dn     [gvm_pkg::LANES];
  logic signed [gvm_pkg::DIST_W-1:0]               dold   [gvm_pkg::LANES];
  logic [gvm_pkg::DIST_W-1:0]                      adn    [gvm_pkg::LANES];
  logic [gvm_pkg::DIST_W-1:0]                      adold  [gvm_pkg::LANES];
  logic signed [gvm_pkg::VOLT_W-1:0]               res    [gvm_pkg::LANES];

  // Per-lane view of the configuration.
  always_comb begin
    gain[gvm_pkg::LANE_X]   = gain_x_q;
    gain[gvm_pkg::LANE_Y]   = {1'b0, gain_y_q};
    size[gvm_pkg::LANE_X]   = SIZE_X;
    size[gvm_pkg::LANE_Y]   = SIZE_Y;
    offset[gvm_pkg::LANE_X] = offset_x_q;
    offset[gvm_pkg::LANE_Y] = offset_y_q;
    invert[gvm_pkg::LANE_X] = mode_q[gvm_pkg::MODE_INV_X];
    invert[gvm_pkg::LANE_Y] = mode_q[gvm_pkg::MODE_INV_Y];
  end

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_x_q   <= gvm_pkg::GAIN_W'(100);
      gain_y_q   <= gvm_pkg::GAIN_Y_W'(100);
      range_q    <= gvm_pkg::RANGE_W'(20000);
      out_min_q  <= -gvm_pkg::VOLT_W'(10000);
      offset_x_q <= '0;
      offset_y_q <= '0;
      mode_q     <= gvm_pkg::MODE_W'(1);
    end else if (cfg_we_i) begin
      case (gvm_pkg::cfg_reg_e'(cfg_idx_i))
        gvm_pkg::REG_GAIN_X:   gain_x_q   <= cfg_data_i[gvm_pkg::GAIN_W-1:0];
        gvm_pkg::REG_GAIN_Y:   gain_y_q   <= cfg_data_i[gvm_pkg::GAIN_Y_W-1:0];
        gvm_pkg::REG_RANGE:    range_q    <= cfg_data_i;
        gvm_pkg::REG_OUT_MIN:  out_min_q  <= cfg_data_i;
        gvm_pkg::REG_OFFSET_X: offset_x_q <= cfg_data_i;
        gvm_pkg::REG_OFFSET_Y: offset_y_q <= cfg_data_i;
        gvm_pkg::REG_MODE:     mode_q     <= cfg_data_i[gvm_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Numerator product and divisor, one multiply per lane.
  always_comb begin
    for (int l = 0; l < gvm_pkg::LANES; l++) begin
      diff[l]  = $signed({2'b00, pix_q[l]}) -
                 $signed({{(gvm_pkg::DIFF_W-gvm_pkg::GAIN_W-4){1'b0}}, gain[l], 4'b0000});
      num_d[l] = diff[l] * $signed({1'b0, range_q});
      dbase[l] = size[l] -
                 $signed({{(gvm_pkg::DBASE_W-gvm_pkg::GAIN_W-1){1'b0}}, gain[l], 1'b0});
    end
  end

  // Magnitudes for the dividers.
  always_comb begin
    for (int l = 0; l < gvm_pkg::LANES; l++) begin
      num_abs[l] = num_q[l][gvm_pkg::NUM_W-1] ? -num_q[l] : num_q[l];
      den_abs[l] = den_q[l][gvm_pkg::DEN_W-1] ? -den_q[l] : den_q[l];
    end
  end

  // One serial divider per lane.
  for (genvar g = 0; g < gvm_pkg::LANES; g++) begin : g_div
    gvm_div u_div (
      .clk_i      (clk_i),
      .load_i     (cmd_i.load),
      .step_i     (cmd_i.step),
      .dividend_i (num_abs[g][gvm_pkg::NMAG_W-1:0]),
      .divisor_i  (den_abs[g][gvm_pkg::DMAG_W-1:0]),
      .quotient_o (quo[g])
    );
  end

  // Sign the quotient, add the minimum, invert, offset and saturate.
  always_comb begin
    for (int l = 0; l < gvm_pkg::LANES; l++) begin
      qs[l] = $signed({{(gvm_pkg::ACC_W-gvm_pkg::NMAG_W){1'b0}}, quo[l]});
      if (dzero_q[l]) begin
        qs[l] = '0;
      end else if (neg_q[l]) begin
        qs[l] = -qs[l];
      end
      v[l] = qs[l] + gvm_pkg::ACC_W'(out_min_q);
      r[l] = invert[l] ? (-v[l] - gvm_pkg::ACC_W'(offset[l]))
                       : (v[l] - gvm_pkg::ACC_W'(offset[l]));
      clip_l[l] = 1'b0;
      sat[l]    = r[l][gvm_pkg::VOLT_W-1:0];
      if (r[l] > gvm_pkg::ACC_W'(32767)) begin
        sat[l]    = 16'sh7fff;
        clip_l[l] = 1'b1;
      end else if (r[l] < -gvm_pkg::ACC_W'(32768)) begin
        sat[l]    = 16'sh8000;
        clip_l[l] = 1'b1;
      end
    end
  end

  // Spike filter with fill phase; disabled filter passes the sample through.
  always_comb begin
    fill_d = fill_q;
    for (int l = 0; l < gvm_pkg::LANES; l++) begin
      h0_d[l]  = h0_q[l];
      h1_d[l]  = h1_q[l];
      res[l]   = map_q[l];
      dn[l]    = gvm_pkg::DIST_W'(h0_q[l]) - gvm_pkg::DIST_W'(map_q[l]);
      dold[l]  = gvm_pkg::DIST_W'(h0_q[l]) - gvm_pkg::DIST_W'(h1_q[l]);
      adn[l]   = dn[l][gvm_pkg::DIST_W-1] ? -dn[l] : dn[l];
      adold[l] = dold[l][gvm_pkg::DIST_W-1] ? -dold[l] : dold[l];
      if (mode_q[gvm_pkg::MODE_FILT]) begin
        h0_d[l] = map_q[l];
        if (fill_q != gvm_pkg::FILL_FULL) begin
          // Filling: push and output the oldest sample held.
          h1_d[l] = h0_q[l];
          case (fill_q)
            2'd0:    res[l] = map_q[l];
            2'd1:    res[l] = h0_q[l];
            default: res[l] = h1_q[l];
          endcase
        end else begin
          // Replace a strict peak or valley by its closer neighbour.
          res[l] = h0_q[l];
          if (((h1_q[l] > h0_q[l]) && (h0_q[l] < map_q[l])) ||
              ((h1_q[l] < h0_q[l]) && (h0_q[l] > map_q[l]))) begin
            res[l] = (adold[l] > adn[l]) ? map_q[l] : h1_q[l];
          end
          h1_d[l] = res[l];
        end
      end
    end
    if (mode_q[gvm_pkg::MODE_FILT] && (fill_q != gvm_pkg::FILL_FULL)) begin
      fill_d = fill_q + 2'd1;
    end
  end

  // Working registers, stepped by the controller.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pix_q[gvm_pkg::LANE_X] <= in_word_i.pupil_x;
      pix_q[gvm_pkg::LANE_Y] <= in_word_i.pupil_y;
    end
    for (int l = 0; l < gvm_pkg::LANES; l++) begin
      if (cmd_i.mul) begin
        num_q[l] <= num_d[l];
        den_q[l] <= {dbase[l], 4'b0000};
      end
      if (cmd_i.load) begin
        neg_q[l]   <= num_q[l][gvm_pkg::NUM_W-1] ^ den_q[l][gvm_pkg::DEN_W-1];
        dzero_q[l] <= (den_q[l] == '0);
      end
      if (cmd_i.fin) begin
        map_q[l] <= sat[l];
      end
    end
    if (cmd_i.fin) begin
      clip_q <= |clip_l;
    end
    if (cmd_i.emit) begin
      out_q.volt_x_mv <= res[gvm_pkg::LANE_X];
      out_q.volt_y_mv <= res[gvm_pkg::LANE_Y];
      out_q.clipped   <= clip_q;
    end
  end

  // History and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      for (int l = 0; l < gvm_pkg::LANES; l++) begin
        h0_q[l] <= '0;
        h1_q[l] <= '0;
      end
    end else if (cmd_i.emit) begin
      fill_q <= fill_d;
      for (int l = 0; l < gvm_pkg::LANES; l++) begin
        h0_q[l] <= h0_d[l];
        h1_q[l] <= h1_d[l];
      end
    end
  end

  // Output word valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_word_o     = out_q;

  // A word is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> sts_o.out_free)
    else $error("word emitted into an occupied output register");

  // An emitted word is presented on the next cycle.
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("emitted word not presented");

  // With the filter off the fill count is left alone.
  a_fill_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && !mode_q[gvm_pkg::MODE_FILT]) |=> $stable(fill_q))
    else $error("fill count moved with the filter disabled");

endmodule

### rtl/gvm_ctrl.sv
// Controller: sequences capture, multiply, divide, finish and emit for each word.
module gvm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  gvm_pkg::sts_t   sts_i,
  output gvm_pkg::cmd_t   cmd_o
);

  localparam logic [gvm_pkg::DIV_CNT_W-1:0] CNT_LAST =
    gvm_pkg::DIV_CNT_W'(gvm_pkg::NMAG_W - 1);

  gvm_pkg::state_e                 state_q, state_d;
  logic [gvm_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;

  // Next state and divide step count.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      gvm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = gvm_pkg::ST_MUL;
        end
      end
      gvm_pkg::ST_MUL: begin
        state_d = gvm_pkg::ST_LOAD;
      end
      gvm_pkg::ST_LOAD: begin
        state_d = gvm_pkg::ST_DIV;
        cnt_d   = '0;
      end
      gvm_pkg::ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = gvm_pkg::ST_FIN;
        end
      end
      gvm_pkg::ST_FIN: begin
        state_d = gvm_pkg::ST_EMIT;
      end
      gvm_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = gvm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gvm_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o         = '0;
    in_stall_o    = (state_q != gvm_pkg::ST_IDLE);
    cmd_o.capture = (state_q == gvm_pkg::ST_IDLE) && in_valid_i;
    cmd_o.mul     = (state_q == gvm_pkg::ST_MUL);
    cmd_o.load    = (state_q == gvm_pkg::ST_LOAD);
    cmd_o.step    = (state_q == gvm_pkg::ST_DIV);
    cmd_o.fin     = (state_q == gvm_pkg::ST_FIN);
    cmd_o.emit    = (state_q == gvm_pkg::ST_EMIT) && sts_i.out_free;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gvm_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // An accepted word starts the multiply on the next cycle.
  a_accept_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == gvm_pkg::ST_MUL))
    else $error("accepted word did not start the multiply");

  // The divide phase ends after exactly the last step.
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == gvm_pkg::ST_DIV) && (cnt_q == CNT_LAST)) |=> (state_q == gvm_pkg::ST_FIN))
    else $error("divide phase did not end after the last step");

  // A blocked output holds the controller in the emit state.
  a_emit_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == gvm_pkg::ST_EMIT) && !sts_i.out_free) |=> (state_q == gvm_pkg::ST_EMIT))
    else $error("controller left emit with the output blocked");

endmodule

### rtl/gaze_volt_map_spike_filter.sv
// Top level: pupil centroid to millivolt mapper with per-axis spike filter.
//
//   Channel   Direction  Handshake               Word
//   in        input      in_valid_i / in_stall_o    pupil_x, pupil_y (Q12.4 pixels)
//   out       output     out_valid_o / out_stall_i  volt_x_mv, volt_y_mv, clipped
//   cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// From acceptance to the next acceptance, when the output is free, a word passes
// through the multiply and load states, the divide state that steps the per-axis
// restoring divider once per quotient bit, the finish and emit states and the idle
// state that takes the next word, with both axes in parallel.
// The result waits in an output register, so a new word is accepted while it is held.
// A stalled output holds the controller in its emit state until the register frees.
// Reset (rst_ni low, asynchronous) restores register defaults and clears the history.
module gaze_volt_map_spike_filter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gvm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gvm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  gvm_pkg::in_word_t                  in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output gvm_pkg::out_word_t                 out_word_o
);

  gvm_pkg::cmd_t cmd;
  gvm_pkg::sts_t sts;

  // Sequencer.
  gvm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic, filter and output register.
  gvm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule
